[sv/rac_pkg.sv]
// Shared types, codes and sizes for the repeater access controller.
// Depends on nothing; every other file imports it.
package rac_pkg;

    // Peak store geometry and tone detect limits.
    localparam int PEAK_DEPTH = 16;
    localparam int MIN_FILL   = 10;
    localparam int OPEN_TICKS = 2;
    localparam int PEAK_IDX_W = $clog2(PEAK_DEPTH);
    localparam int FILL_W     = $clog2(PEAK_DEPTH + 1);

    // Field widths.
    localparam int FREQ_W = 14;
    localparam int MAG_W  = 32;
    localparam int LVL_W  = 12;
    localparam int TOL_W  = 11;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 4;

    // Item kinds.
    localparam logic [1:0] OP_PEAK   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_BUTTON = 2'd2;

    // Modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_OPEN   = 2'd1;
    localparam logic [1:0] MODE_REPEAT = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    // Clip start pulse codes.
    localparam logic [1:0] CLIP_NONE  = 2'd0;
    localparam logic [1:0] CLIP_OPEN  = 2'd1;
    localparam logic [1:0] CLIP_CLOSE = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_SQUELCH   = 4'd0;
    localparam logic [IDX_W-1:0] REG_TONE_CTR  = 4'd1;
    localparam logic [IDX_W-1:0] REG_TONE_TOL  = 4'd2;
    localparam logic [IDX_W-1:0] REG_TONE_MAG  = 4'd3;
    localparam logic [IDX_W-1:0] REG_ANNOUNCE  = 4'd4;
    localparam logic [IDX_W-1:0] REG_HANG      = 4'd5;
    localparam logic [IDX_W-1:0] REG_RPT_EN    = 4'd6;
    localparam logic [IDX_W-1:0] REG_CTCSS_EN  = 4'd7;

    // Input beat.
    typedef struct packed {
        logic [1:0]              op;
        logic [FREQ_W-1:0]       peak_frequency;
        logic [MAG_W-1:0]        peak_magnitude;
        logic signed [LVL_W-1:0] volume_level;
        logic                    button_level;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic [1:0] mode;
        logic       carrier_detect;
        logic       rx_led;
        logic       tx_led;
        logic       pass_input;
        logic       pass_player;
        logic       ctcss_on;
        logic [1:0] start_clip;
    } t_out;

    // Audio routing flags.
    typedef struct packed {
        logic rx_led;
        logic tx_led;
        logic pass_input;
        logic pass_player;
        logic ctcss_on;
    } t_route;

    // Sequencer to peak chain controls.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
    } t_chain_ctrl;

    // Peak chain status back to the sequencer.
    typedef struct packed {
        logic hit;
        logic last;
    } t_chain_stat;

    // Tone detector settings.
    typedef struct packed {
        logic [FREQ_W-1:0] center;
        logic [TOL_W-1:0]  tolerance;
        logic [MAG_W-1:0]  mag_min;
    } t_tone_cfg;

endpackage

[sv/repeater_access_controller_top.sv]
// Repeater access controller: mode sequencer, settings and output register.
// Peak, button and other beats give a registered result in the cycle after acceptance;
// a tick beat first rotates the peak chain in the scan state, then loads its result in the done state.
// One non-tick beat per cycle while the output is free; a tick holds off new beats until its result is loaded.
// Reset (synchronous, active low) restores all settings, idle mode and an empty peak store.
// Depends on rac_pkg and rac_peak_chain.
module repeater_access_controller_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  rac_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output rac_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [rac_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [rac_pkg::CFG_W-1:0] i_cfg_data
);
    import rac_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Settings.
    logic signed [LVL_W-1:0] r_squelch;
    logic [FREQ_W-1:0]       r_tone_ctr;
    logic [TOL_W-1:0]        r_tone_tol;
    logic [MAG_W-1:0]        r_tone_mag;
    logic [CNT_W-1:0]        r_announce;
    logic [CNT_W-1:0]        r_hang;
    logic                    r_rpt_en;
    logic                    r_ctcss_en;

    // Sequencer state.
    logic [1:0]              r_state, n_state;
    logic [1:0]              r_mode, n_mode;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_carrier, n_carrier;
    logic                    r_btn, n_btn;
    t_route                  r_route, n_route;
    logic signed [LVL_W-1:0] r_vol;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_load;
    logic [1:0]              w_clip;
    t_chain_ctrl             w_ctrl;
    t_chain_stat             w_stat;
    t_tone_cfg               w_tone_cfg;

    // Saturating tick counter step.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    // Routing for a mode being entered.
    function automatic t_route route_for(input logic [1:0] m, input t_route cur,
                                         input logic ctcss_en);
        t_route r;
        r = cur;
        if (m == MODE_IDLE) begin
            r = '{rx_led: 1'b1, tx_led: 1'b0, pass_input: 1'b0,
                  pass_player: 1'b0, ctcss_on: 1'b0};
        end else begin
            r.rx_led      = 1'b0;
            r.tx_led      = 1'b1;
            r.pass_input  = (m == MODE_REPEAT);
            r.pass_player = (m != MODE_REPEAT);
            if (ctcss_en) begin
                r.ctcss_on = 1'b1;
            end
        end
        route_for = r;
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_tone_cfg = '{center: r_tone_ctr, tolerance: r_tone_tol, mag_min: r_tone_mag};

    rac_peak_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_freq  (i_in_data.peak_frequency),
        .i_mag   (i_in_data.peak_magnitude),
        .i_cfg   (w_tone_cfg),
        .o_stat  (w_stat)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        logic [1:0]       tgt;
        logic             go;
        logic [CNT_W-1:0] c;
        n_state   = r_state;
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_carrier = r_carrier;
        n_btn     = r_btn;
        n_route   = r_route;
        w_load    = 1'b0;
        w_clip    = CLIP_NONE;
        w_ctrl    = '0;
        tgt       = MODE_IDLE;
        go        = 1'b0;
        c         = r_cnt;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.op)
                        OP_PEAK: begin
                            w_ctrl.load = 1'b1;
                            w_load      = 1'b1;
                        end
                        OP_TICK: begin
                            w_ctrl.scan_start = 1'b1;
                            n_state           = ST_SCAN;
                        end
                        OP_BUTTON: begin
                            if (!r_btn && i_in_data.button_level) begin
                                go  = 1'b1;
                                tgt = MODE_OPEN;
                            end
                            n_btn  = i_in_data.button_level;
                            w_load = 1'b1;
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_ctrl.scan_step = 1'b1;
                if (w_stat.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_carrier = (r_vol > r_squelch);
                    case (r_mode)
                        MODE_IDLE: begin
                            c = (w_stat.hit && n_carrier) ? sat_inc(r_cnt) : '0;
                            if (c >= CNT_W'(OPEN_TICKS)) begin
                                go  = 1'b1;
                                tgt = MODE_OPEN;
                                c   = '0;
                            end
                        end
                        MODE_OPEN: begin
                            c = sat_inc(r_cnt);
                            if (c > r_announce) begin
                                go  = 1'b1;
                                tgt = MODE_REPEAT;
                                c   = '0;
                            end
                        end
                        MODE_REPEAT: begin
                            c = !n_carrier ? sat_inc(r_cnt) : '0;
                            if (c > r_hang) begin
                                go  = 1'b1;
                                tgt = MODE_CLOSE;
                                c   = '0;
                            end
                        end
                        default: begin
                            c = sat_inc(r_cnt);
                            if (c > r_announce) begin
                                go  = 1'b1;
                                tgt = MODE_IDLE;
                                c   = '0;
                            end
                        end
                    endcase
                    n_cnt   = c;
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Mode entry, gated by the repeater enable.
        if (go && r_rpt_en) begin
            n_mode  = tgt;
            n_route = route_for(tgt, r_route, r_ctcss_en);
            if (tgt == MODE_OPEN) begin
                w_clip = CLIP_OPEN;
            end else if (tgt == MODE_CLOSE) begin
                w_clip = CLIP_CLOSE;
            end
        end

        // Turning the subtone setting off drops the subtone at once.
        if (i_cfg_we && (i_cfg_idx == REG_CTCSS_EN) && !i_cfg_data[0]) begin
            n_route.ctcss_on = 1'b0;
        end
    end

    // Settings registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squelch  <= -LVL_W'(300);
            r_tone_ctr <= FREQ_W'(1750);
            r_tone_tol <= TOL_W'(100);
            r_tone_mag <= MAG_W'(100000);
            r_announce <= CNT_W'(3);
            r_hang     <= CNT_W'(10);
            r_rpt_en   <= 1'b1;
            r_ctcss_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SQUELCH:  r_squelch  <= signed'(i_cfg_data[LVL_W-1:0]);
                REG_TONE_CTR: r_tone_ctr <= i_cfg_data[FREQ_W-1:0];
                REG_TONE_TOL: r_tone_tol <= i_cfg_data[TOL_W-1:0];
                REG_TONE_MAG: r_tone_mag <= i_cfg_data[MAG_W-1:0];
                REG_ANNOUNCE: r_announce <= i_cfg_data[CNT_W-1:0];
                REG_HANG:     r_hang     <= i_cfg_data[CNT_W-1:0];
                REG_RPT_EN:   r_rpt_en   <= i_cfg_data[0];
                REG_CTCSS_EN: r_ctcss_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_IDLE;
            r_cnt       <= '0;
            r_carrier   <= 1'b0;
            r_btn       <= 1'b1;
            r_route     <= '{rx_led: 1'b1, tx_led: 1'b0, pass_input: 1'b0,
                             pass_player: 1'b0, ctcss_on: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_carrier <= n_carrier;
            r_btn     <= n_btn;
            r_route   <= n_route;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload and the latched tick volume.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_data.op == OP_TICK)) begin
            r_vol <= i_in_data.volume_level;
        end
        if (w_load) begin
            r_out.mode           <= n_mode;
            r_out.carrier_detect <= n_carrier;
            r_out.rx_led         <= n_route.rx_led;
            r_out.tx_led         <= n_route.tx_led;
            r_out.pass_input     <= n_route.pass_input;
            r_out.pass_player    <= n_route.pass_player;
            r_out.ctcss_on       <= n_route.ctcss_on;
            r_out.start_clip     <= w_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/rac_peak_cell.sv]
// One storage cell of the peak chain: a frequency and magnitude pair.
// Depends on rac_pkg.
module rac_peak_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rac_pkg::FREQ_W-1:0] i_freq,
    input  logic [rac_pkg::MAG_W-1:0]  i_mag,
    output logic [rac_pkg::FREQ_W-1:0] o_freq,
    output logic [rac_pkg::MAG_W-1:0]  o_mag
);
    import rac_pkg::*;

    logic [FREQ_W-1:0] r_freq;
    logic [MAG_W-1:0]  r_mag;

    // Take the entry at the cell input whenever the chain moves.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_freq <= i_freq;
            r_mag  <= i_mag;
        end
    end

    assign o_freq = r_freq;
    assign o_mag  = r_mag;

endmodule

[sv/rac_peak_chain.sv]
// Row of peak cells with the tone detector at its tail.
// New peaks shift in at the head; a scan rotates the row once through the tail.
// Depends on rac_pkg and rac_peak_cell.
module rac_peak_chain (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rac_pkg::t_chain_ctrl       i_ctrl,
    input  logic [rac_pkg::FREQ_W-1:0] i_freq,
    input  logic [rac_pkg::MAG_W-1:0]  i_mag,
    input  rac_pkg::t_tone_cfg         i_cfg,
    output rac_pkg::t_chain_stat       o_stat
);
    import rac_pkg::*;

    localparam int SUM_W = FILL_W + 1;
    localparam int TONE_W = FREQ_W + 2;

    logic [FREQ_W-1:0] w_freq [PEAK_DEPTH];
    logic [MAG_W-1:0]  w_mag  [PEAK_DEPTH];
    logic [FREQ_W-1:0] w_head_freq;
    logic [MAG_W-1:0]  w_head_mag;
    logic              w_move;

    logic [FILL_W-1:0]         r_fill;
    logic [PEAK_IDX_W-1:0]     r_scan_idx;
    logic                      r_hit;
    logic signed [TONE_W-1:0]  r_lo;
    logic signed [TONE_W-1:0]  r_hi;
    logic                      r_enough;

    logic signed [TONE_W-1:0]  w_tail_f;
    logic                      w_tail_written;
    logic                      w_match;

    // Head input: a new peak on load, the tail entry on rotation.
    assign w_move      = i_ctrl.load | i_ctrl.scan_step;
    assign w_head_freq = i_ctrl.load ? i_freq : w_freq[PEAK_DEPTH-1];
    assign w_head_mag  = i_ctrl.load ? i_mag  : w_mag[PEAK_DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < PEAK_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                rac_peak_cell u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_move),
                    .i_freq (w_head_freq),
                    .i_mag  (w_head_mag),
                    .o_freq (w_freq[g]),
                    .o_mag  (w_mag[g])
                );
            end else begin : g_body
                rac_peak_cell u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_move),
                    .i_freq (w_freq[g-1]),
                    .i_mag  (w_mag[g-1]),
                    .o_freq (w_freq[g]),
                    .o_mag  (w_mag[g])
                );
            end
        end
    endgenerate

    // Tone window bounds, kept up to date from the settings.
    always_ff @(posedge i_clk) begin
        r_lo <= signed'(TONE_W'(i_cfg.center)) - signed'(TONE_W'(i_cfg.tolerance));
        r_hi <= signed'(TONE_W'(i_cfg.center)) + signed'(TONE_W'(i_cfg.tolerance));
        r_enough <= (32'(r_fill) >= 32'(MIN_FILL));
    end

    // At scan step s the tail holds the entry that sat in cell DEPTH-1-s.
    assign w_tail_f       = signed'(TONE_W'(w_freq[PEAK_DEPTH-1]));
    assign w_tail_written = (SUM_W'(r_fill) + SUM_W'(r_scan_idx)) >= SUM_W'(PEAK_DEPTH);
    assign w_match        = w_tail_written && (w_tail_f < r_hi) && (w_tail_f > r_lo)
                            && (w_mag[PEAK_DEPTH-1] > i_cfg.mag_min);

    // Fill count, scan position and hit accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_scan_idx <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_ctrl.load && (r_fill != FILL_W'(PEAK_DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_ctrl.scan_start) begin
                r_scan_idx <= '0;
                r_hit      <= 1'b0;
            end else if (i_ctrl.scan_step) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_hit      <= r_hit | w_match;
            end
        end
    end

    assign o_stat.hit  = r_hit & r_enough;
    assign o_stat.last = (r_scan_idx == PEAK_IDX_W'(PEAK_DEPTH - 1));

endmodule
